>>> rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg: shared definitions for the palette letterbox scaler
// Screen and frame geometry, field widths, function codes and beat metadata.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 480;
  localparam int unsigned SCREEN_HEIGHT = 320;
  localparam int unsigned ROW_STRIDE    = 368;
  localparam int unsigned SOURCE_ROWS   = 242;
  localparam int unsigned FRAME_DEPTH   = ROW_STRIDE * SOURCE_ROWS;

  localparam int unsigned ADDR_W   = 17;
  localparam int unsigned WIDTH_W  = 9;
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned CIDX_W   = 8;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned PROD_W   = 18;
  localparam int unsigned QUOT_W   = 9;

  // Numerator width and step count of the scale unit's serial divider.
  localparam int unsigned NUM_W     = 18;
  localparam int unsigned SDIV_STEP = NUM_W;

  localparam int unsigned PAL_DEPTH = 256;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 9'd256;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 8'd240;

  // Scaled size and offsets for the reset picture size.
  localparam int unsigned RST_SW0 = (256 * SCREEN_HEIGHT) / 240;
  localparam int unsigned RST_SW  = (RST_SW0 > SCREEN_WIDTH) ? SCREEN_WIDTH : RST_SW0;
  localparam int unsigned RST_SH  = (RST_SW0 > SCREEN_WIDTH) ?
                                    (240 * SCREEN_WIDTH) / 256 : SCREEN_HEIGHT;
  localparam int unsigned RST_OX  = (SCREEN_WIDTH - RST_SW) / 2;
  localparam int unsigned RST_OY  = (SCREEN_HEIGHT - RST_SH) / 2;

  typedef enum logic [1:0] {
    FUNC_WR_PIXEL   = 2'd0,
    FUNC_WR_PALETTE = 2'd1,
    FUNC_RENDER     = 2'd2,
    FUNC_UNUSED     = 2'd3
  } func_e;

  typedef enum logic {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } cfg_idx_e;

  // Metadata that travels with every beat through the pipeline.
  typedef struct packed {
    func_e               func;
    logic                in_pic;
    logic [ADDR_W-1:0]   waddr;
    logic [CIDX_W-1:0]   cidx;
    logic [COLOR_W-1:0]  pcol;
  } meta_t;

  // One partial restoring division: remainder and shifting low word.
  typedef struct packed {
    logic [QUOT_W-1:0] rem;
    logic [QUOT_W-1:0] low;
  } div_t;

endpackage

>>> rtl/palette_letterbox_scaler.sv
// ----------------------------------------------------------------------------
// palette_letterbox_scaler
// Nearest-neighbor letterbox scaler over a palette-indexed source frame.
// ----------------------------------------------------------------------------
// A render beat's result comes out of the output register after passing every stage below.
// Throughput: one beat per cycle while busy is low; the pipeline never stalls, as the receiver cannot hold off.
// busy is high after a configuration write while the scale unit recomputes the scaled size;
// a second division runs when the picture is fitted to the screen width, none for a zero size.
// Reset clears all valid bits and loads the default 256 x 240 picture size
// with its precomputed scale; the frame and palette memories are not cleared.
module palette_letterbox_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [plb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]                    func_i,
  input  logic [plb_pkg::ADDR_W-1:0]    source_address_i,
  input  logic [plb_pkg::CIDX_W-1:0]    color_index_i,
  input  logic [plb_pkg::COLOR_W-1:0]   palette_color_i,
  input  logic [plb_pkg::COORD_W-1:0]   screen_x_i,
  input  logic [plb_pkg::COORD_W-1:0]   screen_y_i,
  output logic                          done_o,
  output logic [plb_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          inside_picture_o
);
  import plb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_DIV_W = 5'b00100,
    ST_DIV_H = 5'b01000,
    ST_DONE  = 5'b10000
  } scale_state_e;

  // --------------------------------------------------------------------------
  // Configuration registers and the scale unit.
  // The scaled size depends on the configuration only, so it is worked out
  // once per write by a shared restoring divider, one quotient bit a cycle.
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  src_w_q;
  logic [HEIGHT_W-1:0] src_h_q;
  logic [COORD_W-1:0]  sw_q, sh_q, ox_q, oy_q;
  logic                en_q;

  scale_state_e        st_q, st_d;
  logic [NUM_W-1:0]    snum_q, snum_d;
  logic [WIDTH_W:0]    srem_q, srem_d;
  logic [WIDTH_W-1:0]  sden_q, sden_d;
  logic [4:0]          scnt_q, scnt_d;
  logic [COORD_W-1:0]  sw_d, sh_d, ox_d, oy_d;
  logic                en_d;

  logic [WIDTH_W+1:0]  srem_sh;
  logic                sge;
  logic [NUM_W-1:0]    squot;

  always_comb begin
    srem_sh = {srem_q, snum_q[NUM_W-1]};
    sge     = (srem_sh >= {2'b00, sden_q});
    squot   = {snum_q[NUM_W-2:0], sge};
  end

  always_comb begin
    st_d   = st_q;
    snum_d = snum_q;
    srem_d = srem_q;
    sden_d = sden_q;
    scnt_d = scnt_q;
    sw_d   = sw_q;
    sh_d   = sh_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    en_d   = en_q;
    case (st_q)
      ST_IDLE: begin
      end
      ST_START: begin
        if (src_w_q == '0 || src_h_q == '0) begin
          en_d = 1'b0;
          st_d = ST_IDLE;
        end else begin
          snum_d = NUM_W'(src_w_q) * NUM_W'(SCREEN_HEIGHT);
          sden_d = WIDTH_W'(src_h_q);
          srem_d = '0;
          scnt_d = '0;
          st_d   = ST_DIV_W;
        end
      end
      ST_DIV_W, ST_DIV_H: begin
        srem_d = sge ? (WIDTH_W+1)'(srem_sh - {2'b00, sden_q}) : (WIDTH_W+1)'(srem_sh);
        snum_d = squot;
        scnt_d = scnt_q + 5'd1;
        if (scnt_q == 5'(SDIV_STEP - 1)) begin
          if (st_q == ST_DIV_H) begin
            sw_d = COORD_W'(SCREEN_WIDTH);
            sh_d = squot[COORD_W-1:0];
            st_d = ST_DONE;
          end else if (squot > NUM_W'(SCREEN_WIDTH)) begin
            // Too wide for the screen: fit the width and scale the height.
            snum_d = NUM_W'(src_h_q) * NUM_W'(SCREEN_WIDTH);
            sden_d = src_w_q;
            srem_d = '0;
            scnt_d = '0;
            st_d   = ST_DIV_H;
          end else begin
            sw_d = squot[COORD_W-1:0];
            sh_d = COORD_W'(SCREEN_HEIGHT);
            st_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        en_d = (sw_q != '0) && (sh_q != '0);
        ox_d = (COORD_W'(SCREEN_WIDTH) - sw_q) >> 1;
        oy_d = (COORD_W'(SCREEN_HEIGHT) - sh_q) >> 1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    // Any write restarts the computation from the new register values.
    if (cfg_we_i) begin
      st_d = ST_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_WIDTH;
      src_h_q <= RST_HEIGHT;
      st_q    <= ST_IDLE;
      sw_q    <= COORD_W'(RST_SW);
      sh_q    <= COORD_W'(RST_SH);
      ox_q    <= COORD_W'(RST_OX);
      oy_q    <= COORD_W'(RST_OY);
      en_q    <= 1'b1;
      scnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[WIDTH_W-1:0];
          CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      st_q   <= st_d;
      sw_q   <= sw_d;
      sh_q   <= sh_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      en_q   <= en_d;
      scnt_q <= scnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snum_q <= snum_d;
    srem_q <= srem_d;
    sden_q <= sden_d;
  end

  assign busy = (st_q != ST_IDLE);

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: input register.
  // --------------------------------------------------------------------------
  logic               v1_q;
  meta_t              m1_q;
  logic [COORD_W-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    m1_q.func   <= func_e'(func_i);
    m1_q.in_pic <= 1'b0;
    m1_q.waddr  <= source_address_i;
    m1_q.cidx   <= color_index_i;
    m1_q.pcol   <= palette_color_i;
    x1_q        <= screen_x_i;
    y1_q        <= screen_y_i;
  end

  // --------------------------------------------------------------------------
  // Stage 2: remove the letterbox offsets and test against the picture area.
  // --------------------------------------------------------------------------
  logic               v2_q;
  meta_t              m2_q, m2_d;
  logic [COORD_W-1:0] dx2_q, dy2_q, dx2_d, dy2_d;

  always_comb begin
    dx2_d       = x1_q - ox_q;
    dy2_d       = y1_q - oy_q;
    m2_d        = m1_q;
    m2_d.in_pic = en_q && (x1_q >= ox_q) && (y1_q >= oy_q) &&
                  (dx2_d < sw_q) && (dy2_d < sh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    m2_q  <= m2_d;
    dx2_q <= dx2_d;
    dy2_q <= dy2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerators of the nearest-neighbor divisions.
  // --------------------------------------------------------------------------
  logic              v3_q;
  meta_t             m3_q;
  logic [PROD_W-1:0] nx3_q, ny3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    m3_q  <= m2_q;
    nx3_q <= PROD_W'(dx2_q) * PROD_W'(src_w_q);
    ny3_q <= PROD_W'(dy2_q) * PROD_W'(src_h_q);
  end

  // --------------------------------------------------------------------------
  // Stages 4 to 12: pipelined restoring dividers, one quotient bit a stage.
  // Inside the picture the quotient is below the source size, so the upper
  // half of the numerator already stands below the divisor.
  // --------------------------------------------------------------------------
  function automatic div_t div_step(div_t cur, logic [QUOT_W-1:0] den);
    logic [QUOT_W:0] rs;
    logic            ge;
    div_t            nxt;
    rs      = {cur.rem, cur.low[QUOT_W-1]};
    ge      = (rs >= {1'b0, den});
    nxt.rem = ge ? QUOT_W'(rs - {1'b0, den}) : QUOT_W'(rs);
    nxt.low = {cur.low[QUOT_W-2:0], ge};
    return nxt;
  endfunction

  logic  dv_q [QUOT_W];
  meta_t dm_q [QUOT_W];
  div_t  dxq_q [QUOT_W];
  div_t  dyq_q [QUOT_W];
  div_t  dx_in [QUOT_W];
  div_t  dy_in [QUOT_W];
  logic  dv_in [QUOT_W];
  meta_t dm_in [QUOT_W];

  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      if (k == 0) begin
        dv_in[k] = v3_q;
        dm_in[k] = m3_q;
        dx_in[k] = '{rem: nx3_q[PROD_W-1:QUOT_W], low: nx3_q[QUOT_W-1:0]};
        dy_in[k] = '{rem: ny3_q[PROD_W-1:QUOT_W], low: ny3_q[QUOT_W-1:0]};
      end else begin
        dv_in[k] = dv_q[k-1];
        dm_in[k] = dm_q[k-1];
        dx_in[k] = dxq_q[k-1];
        dy_in[k] = dyq_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QUOT_W; k++) dv_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QUOT_W; k++) dv_q[k] <= dv_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QUOT_W; k++) begin
      dm_q[k]  <= dm_in[k];
      dxq_q[k] <= div_step(dx_in[k], sw_q);
      dyq_q[k] <= div_step(dy_in[k], sh_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: frame address of the nearest source pixel.
  // --------------------------------------------------------------------------
  logic              v4_q, oob4_q;
  meta_t             m4_q;
  logic [ADDR_W-1:0] addr4_q;
  logic [PROD_W-1:0] addr4_d;

  assign addr4_d = PROD_W'(dyq_q[QUOT_W-1].low) * PROD_W'(ROW_STRIDE) +
                   PROD_W'(dxq_q[QUOT_W-1].low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= dv_q[QUOT_W-1];
  end

  always_ff @(posedge clk_i) begin
    m4_q    <= dm_q[QUOT_W-1];
    addr4_q <= addr4_d[ADDR_W-1:0];
    oob4_q  <= (addr4_d >= PROD_W'(FRAME_DEPTH));
  end

  // --------------------------------------------------------------------------
  // Stage 14: frame memory. Pixel writes land here so that they keep their
  // order against the reads of render beats.
  // --------------------------------------------------------------------------
  logic [CIDX_W-1:0] frame_mem [FRAME_DEPTH];
  logic [CIDX_W-1:0] fidx5_q;
  logic              v5_q, oob5_q;
  meta_t             m5_q;
  logic              frame_we;

  assign frame_we = v4_q && (m4_q.func == FUNC_WR_PIXEL) &&
                    (m4_q.waddr < ADDR_W'(FRAME_DEPTH));

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[m4_q.waddr] <= m4_q.cidx;
    end
    fidx5_q <= frame_mem[addr4_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    m5_q   <= m4_q;
    oob5_q <= oob4_q;
  end

  // --------------------------------------------------------------------------
  // Stage 15: palette memory, written in the same stage that reads it.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic [COLOR_W-1:0] col6_q;
  logic [CIDX_W-1:0]  pal_raddr;
  logic               v6_q;
  meta_t              m6_q;

  // A source pixel beyond the frame end reads palette index zero.
  assign pal_raddr = oob5_q ? '0 : fidx5_q;

  always_ff @(posedge clk_i) begin
    if (v5_q && (m5_q.func == FUNC_WR_PALETTE)) begin
      pal_mem[m5_q.cidx] <= m5_q.pcol;
    end
    col6_q <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    m6_q <= m5_q;
  end

  // --------------------------------------------------------------------------
  // Stage 16: output register. Only render beats produce a result; border
  // pixels come out black.
  // --------------------------------------------------------------------------
  logic               done_q;
  logic [COLOR_W-1:0] color_q;
  logic               in_pic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v6_q && (m6_q.func == FUNC_RENDER);
  end

  always_ff @(posedge clk_i) begin
    color_q  <= m6_q.in_pic ? col6_q : '0;
    in_pic_q <= m6_q.in_pic;
  end

  assign done_o           = done_q;
  assign pixel_color_o    = color_q;
  assign inside_picture_o = in_pic_q;

endmodule

>>> sim/tb_palette_letterbox_scaler.sv
// ----------------------------------------------------------------------------
// tb_palette_letterbox_scaler: self-checking testbench of the letterbox scaler
// Fills the palette and the source frame through write beats, renders output
// pixels under a range of picture sizes and checks every result against a
// hand-typed value or a behavioral copy of the scaler kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_palette_letterbox_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  import plb_pkg::*;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned RANDOM_BEATS = 1200;
  // Extra wait after the last result so that the pipeline has emptied out.
  localparam int unsigned SETTLE       = 30;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic [1:0]           func_i;
  logic [ADDR_W-1:0]    source_address_i;
  logic [CIDX_W-1:0]    color_index_i;
  logic [COLOR_W-1:0]   palette_color_i;
  logic [COORD_W-1:0]   screen_x_i;
  logic [COORD_W-1:0]   screen_y_i;
  logic                 done_o;
  logic [COLOR_W-1:0]   pixel_color_o;
  logic                 inside_picture_o;

  palette_letterbox_scaler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .source_address_i(source_address_i),
    .color_index_i   (color_index_i),
    .palette_color_i (palette_color_i),
    .screen_x_i      (screen_x_i),
    .screen_y_i      (screen_y_i),
    .done_o          (done_o),
    .pixel_color_o   (pixel_color_o),
    .inside_picture_o(inside_picture_o)
  );

  // One expected rendered pixel.
  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               in_pic;
  } pixel_t;

  // One row of the directed table. Rows with known_result set carry the
  // result typed in by hand; the others are predicted.
  typedef struct {
    func_e              func;
    logic [ADDR_W-1:0]  addr;
    logic [CIDX_W-1:0]  cidx;
    logic [COLOR_W-1:0] pcol;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 known_result;
    logic [COLOR_W-1:0] color;
    logic               in_pic;
  } row_t;

  // Shadow copy of the block's stores and picture size.
  logic [CIDX_W-1:0]  frame_mem [FRAME_DEPTH];
  bit                 frame_written [FRAME_DEPTH];
  logic [COLOR_W-1:0] palette_mem [PAL_DEPTH];
  int unsigned        pic_w;
  int unsigned        pic_h;

  pixel_t      pending_pixels[$];
  int unsigned mismatches;
  int unsigned renders_checked;
  int unsigned border_seen;
  int unsigned picture_seen;
  int unsigned beats_sent;
  int unsigned cycle_count;
  bit          gaps_enabled;

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Works out where an output pixel lands in the source frame. The picture is
  // fitted to the screen with its aspect ratio kept and centered; any zero
  // size, either of the registers or of a scaled side, makes it all border.
  function automatic void map_pixel(input int unsigned x, input int unsigned y,
                                    output bit in_pic, output int unsigned addr);
    int unsigned sw, sh, ox, oy, dx, dy;
    in_pic = 1'b0;
    addr   = 0;
    if (pic_w == 0 || pic_h == 0) return;
    sh = SCREEN_HEIGHT;
    sw = (pic_w * SCREEN_HEIGHT) / pic_h;
    if (sw > SCREEN_WIDTH) begin
      sw = SCREEN_WIDTH;
      sh = (pic_h * SCREEN_WIDTH) / pic_w;
    end
    if (sw == 0 || sh == 0) return;
    ox = (SCREEN_WIDTH - sw) / 2;
    oy = (SCREEN_HEIGHT - sh) / 2;
    if (x < ox || y < oy) return;
    dx = x - ox;
    dy = y - oy;
    if (dx >= sw || dy >= sh) return;
    in_pic = 1'b1;
    addr   = ((dy * pic_h) / sh) * ROW_STRIDE + (dx * pic_w) / sw;
  endfunction

  function automatic pixel_t predict_pixel(input int unsigned x, input int unsigned y);
    pixel_t      p;
    bit          in_pic;
    int unsigned addr;
    logic [CIDX_W-1:0] idx;
    map_pixel(x, y, in_pic, addr);
    p.in_pic = in_pic;
    p.color  = '0;
    if (in_pic) begin
      // An address beyond the frame end reads palette index zero.
      idx     = (addr < FRAME_DEPTH) ? frame_mem[addr] : '0;
      p.color = palette_mem[idx];
    end
    return p;
  endfunction

  // Updates the shadow stores for an accepted beat and queues its result.
  task automatic apply_beat(input row_t r);
    pixel_t p;
    case (r.func)
      FUNC_WR_PIXEL: begin
        if (r.addr < FRAME_DEPTH) begin
          frame_mem[r.addr]     = r.cidx;
          frame_written[r.addr] = 1'b1;
        end
      end
      FUNC_WR_PALETTE: palette_mem[r.cidx] = r.pcol;
      FUNC_RENDER: begin
        if (r.known_result) begin
          p.color  = r.color;
          p.in_pic = r.in_pic;
        end else begin
          p = predict_pixel(r.x, r.y);
        end
        pending_pixels.push_back(p);
      end
      default: ; // The unused code leaves everything as it was.
    endcase
  endtask

  // Mostly back-to-back beats or short gaps, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one beat from the falling edge on and holds it until the block
  // takes it. start stays high into the next beat when no gap follows.
  task automatic send_beat(input row_t r);
    int unsigned gap;
    @(negedge clk_i);
    start            <= 1'b1;
    func_i           <= r.func;
    source_address_i <= r.addr;
    color_index_i    <= r.cidx;
    palette_color_i  <= r.pcol;
    screen_x_i       <= r.x;
    screen_y_i       <= r.y;
    do @(posedge clk_i); while (busy);
    apply_beat(r);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
  endtask

  function automatic row_t blank_row(input func_e f);
    row_t r;
    r.func         = f;
    r.addr         = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    r.cidx         = CIDX_W'($urandom_range(0, PAL_DEPTH - 1));
    r.pcol         = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
    r.x            = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    r.y            = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    r.known_result = 1'b0;
    r.color        = '0;
    r.in_pic       = 1'b0;
    return r;
  endfunction

  // A render must never touch a frame entry that was never written, so any
  // such entry gets a pixel write with random content first.
  task automatic send_render(input int unsigned x, input int unsigned y);
    row_t        r;
    bit          in_pic;
    int unsigned addr;
    map_pixel(x, y, in_pic, addr);
    if (in_pic && addr < FRAME_DEPTH && !frame_written[addr]) begin
      r      = blank_row(FUNC_WR_PIXEL);
      r.addr = ADDR_W'(addr);
      send_beat(r);
    end
    r   = blank_row(FUNC_RENDER);
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    send_beat(r);
  endtask

  // Lets every outstanding result come back and the pipeline empty out.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(input int unsigned w, input int unsigned h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SRC_WIDTH;
    cfg_data_i <= w[CFG_W-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= CFG_SRC_HEIGHT;
    cfg_data_i <= CFG_W'(h[HEIGHT_W-1:0]);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pic_w = 32'(w[WIDTH_W-1:0]);
    pic_h = 32'(h[HEIGHT_W-1:0]);
  endtask

  // Random traffic under one picture size: mostly renders over the screen,
  // with pixel and palette rewrites, stray frame addresses and unused codes.
  task automatic random_phase(input int unsigned beats);
    row_t        r;
    int unsigned roll;
    for (int unsigned i = 0; i < beats; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        if ($urandom_range(0, 9) == 0)
          send_render($urandom_range(0, 511), $urandom_range(0, 511));
        else
          send_render($urandom_range(0, SCREEN_WIDTH - 1),
                      $urandom_range(0, SCREEN_HEIGHT - 1));
      end else if (roll < 82) begin
        r = blank_row(FUNC_WR_PIXEL);
        if ($urandom_range(0, 3) != 0)
          r.addr = ADDR_W'($urandom_range(0, FRAME_DEPTH - 1));
        send_beat(r);
      end else if (roll < 95) begin
        send_beat(blank_row(FUNC_WR_PALETTE));
      end else begin
        send_beat(blank_row(FUNC_UNUSED));
      end
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t p;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result color %h inside %b",
                                  pixel_color_o, inside_picture_o));
      end else begin
        p = pending_pixels.pop_front();
        renders_checked++;
        if (p.in_pic) picture_seen++;
        else border_seen++;
        if (pixel_color_o !== p.color)
          report_mismatch($sformatf("pixel_color %h, expected %h",
                                    pixel_color_o, p.color));
        if (inside_picture_o !== p.in_pic)
          report_mismatch($sformatf("inside_picture %b, expected %b",
                                    inside_picture_o, p.in_pic));
      end
    end
  end

  // Picture sizes for the random phases: extremes, sizes whose scaled side
  // comes out zero, sizes wider than the stride and a few plain ones.
  int unsigned size_w [12] = '{256, 368,   1, 368,   1,   0, 200, 511, 511, 320, 100,  17};
  int unsigned size_h [12] = '{240, 242,   1,   1, 255, 240,   0, 255,   1, 200, 242, 131};

  row_t directed [] = '{
    // Seed two palette entries and the first and last frame words.
    '{FUNC_WR_PALETTE, 17'd0,      8'd0,   16'hFFFF, 9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_WR_PALETTE, 17'd0,      8'd255, 16'h1234, 9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_WR_PIXEL,   17'd0,      8'd255, 16'h0,    9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_WR_PIXEL,   17'd89055,  8'd0,   16'h0,    9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    // A write beyond the frame end and an unused code must change nothing.
    '{FUNC_WR_PIXEL,   17'h1FFFF,  8'd7,   16'h0,    9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_UNUSED,     17'd0,      8'd1,   16'hABCD, 9'd69,  9'd0,   1'b0, 16'h0,    1'b0},
    // With the reset size of 256 x 240 the picture is 341 wide at column 69.
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd69,  9'd0,   1'b1, 16'h1234, 1'b1},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd68,  9'd0,   1'b1, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd0,   9'd0,   1'b1, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd479, 9'd319, 1'b1, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd410, 9'd100, 1'b1, 16'h0,    1'b0},
    // Off the screen altogether.
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd511, 9'd511, 1'b1, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd100, 9'd320, 1'b1, 16'h0,    1'b0},
    // Point the top-left pixel at entry 0 and read it back, then overwrite.
    '{FUNC_WR_PIXEL,   17'd0,      8'd0,   16'h0,    9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd70,  9'd0,   1'b1, 16'hFFFF, 1'b1},
    '{FUNC_WR_PALETTE, 17'd0,      8'd0,   16'h0000, 9'd0,   9'd0,   1'b0, 16'h0,    1'b0},
    '{FUNC_RENDER,     17'd0,      8'd0,   16'h0,    9'd69,  9'd0,   1'b0, 16'h0,    1'b0}
  };

  initial begin
    row_t r;
    rst_ni           = 1'b0;
    start            = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SRC_WIDTH;
    cfg_data_i       = '0;
    func_i           = FUNC_UNUSED;
    source_address_i = '0;
    color_index_i    = '0;
    palette_color_i  = '0;
    screen_x_i       = '0;
    screen_y_i       = '0;
    mismatches       = 0;
    renders_checked  = 0;
    border_seen      = 0;
    picture_seen     = 0;
    beats_sent       = 0;
    cycle_count      = 0;
    gaps_enabled     = 1'b0;
    pic_w            = 32'(RST_WIDTH);
    pic_h            = 32'(RST_HEIGHT);
    foreach (frame_written[i]) frame_written[i] = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset picture size, back to back.
    foreach (directed[i]) send_beat(directed[i]);

    // Fill the whole palette so that any frame index can be rendered.
    gaps_enabled = 1'b1;
    for (int unsigned i = 0; i < PAL_DEPTH; i++) begin
      r      = blank_row(FUNC_WR_PALETTE);
      r.cidx = CIDX_W'(i);
      send_beat(r);
    end

    // One random phase per picture size; every other phase runs without gaps.
    foreach (size_w[i]) begin
      drain();
      write_size(size_w[i], size_h[i]);
      gaps_enabled = (i % 2) == 0;
      random_phase(RANDOM_BEATS / 12);
    end

    drain();
    $display("%0d beats sent, %0d renders checked (%0d in picture, %0d border)",
             beats_sent, renders_checked, picture_seen, border_seen);
    $display("%0d picture sizes exercised including zero and oversize cases",
             $size(size_w));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
